// ===== rtl/cswa_pkg.sv =====
// Shared types, constants and tables for the cosine-sum window block.
package cswa_pkg;

  localparam int MAX_FRAME   = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int POS_BITS    = $clog2(MAX_FRAME);
  localparam int FRAME_BITS  = 13;
  localparam int KIND_BITS   = 2;
  localparam int PHASE_BITS  = 24;
  localparam int DIV_STEPS   = PHASE_BITS + 1;
  localparam int CNT_BITS    = $clog2(DIV_STEPS);
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_BITS   = $clog2(CORDIC_STEPS);
  localparam int ROT_BITS    = 19;
  localparam int MUL_A_BITS  = 32;
  localparam int MUL_B_BITS  = 19;
  localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;
  localparam int W30_BITS    = 31;
  localparam int ADDR_BITS   = 3;
  localparam int DATA_BITS   = 32;

  localparam logic signed [ROT_BITS-1:0]   CORDIC_GAIN = 19'sd39797;
  localparam logic signed [MUL_B_BITS-1:0] HALF_PI_Q16 = 19'sd102944;

  // Window constants in Q16.
  localparam logic [15:0] COEF_0P54 = 16'd35389;
  localparam logic [15:0] COEF_0P46 = 16'd30147;
  localparam logic [15:0] COEF_0P50 = 16'd32768;
  localparam logic [15:0] COEF_0P42 = 16'd27525;
  localparam logic [15:0] COEF_0P08 = 16'd5243;

  localparam logic [KIND_BITS-1:0] KIND_HAMMING  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_HANN     = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_BLACKMAN = 2'd2;

  localparam logic REG_WINDOW_KIND  = 1'b0;
  localparam logic REG_FRAME_LENGTH = 1'b1;

  localparam logic [KIND_BITS-1:0]  RESET_KIND   = KIND_HAMMING;
  localparam logic [FRAME_BITS-1:0] RESET_LENGTH = 13'd1024;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_ZMUL,
    ST_ROT,
    ST_COSSEL,
    ST_WMUL1,
    ST_WMUL2,
    ST_CLAMP,
    ST_SMUL,
    ST_FINISH
  } state_t;

  // Arctangent of 2^-k in Q16, rounded.
  function automatic logic signed [ROT_BITS-1:0] atan_q16(input logic [STEP_BITS-1:0] k);
    logic signed [ROT_BITS-1:0] v;
    case (k)
      4'd0:    v = 19'sd51472;
      4'd1:    v = 19'sd30386;
      4'd2:    v = 19'sd16055;
      4'd3:    v = 19'sd8150;
      4'd4:    v = 19'sd4091;
      4'd5:    v = 19'sd2047;
      4'd6:    v = 19'sd1024;
      4'd7:    v = 19'sd512;
      4'd8:    v = 19'sd256;
      4'd9:    v = 19'sd128;
      4'd10:   v = 19'sd64;
      4'd11:   v = 19'sd32;
      4'd12:   v = 19'sd16;
      4'd13:   v = 19'sd8;
      4'd14:   v = 19'sd4;
      4'd15:   v = 19'sd2;
      default: v = 19'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/cosine_sum_window_apply.sv =====
// Cosine-sum window (Hamming, Hann, Blackman) applied to a sample stream.
//
// Input transactions carry sample_in (signed Q1.15) and frame_restart. A
// transaction completes at a clock edge with in_valid high and in_stall low.
// Output transactions carry sample_out, position and frame_last under
// out_valid/out_stall. Registers: window_kind at byte 0, frame_length at 4.
//
// Each sample first goes through a 25-step restoring divider that turns its
// position into a phase, then a 16-step CORDIC for the cosine, then a few
// passes through one shared 32x19 multiplier for the coefficient and the
// product; Blackman runs the CORDIC twice. The result then goes to the output
// register, and the sequencer goes back to idle before it takes the next
// sample, so it works on one sample at a time. With frame_length below 2
// samples pass through unchanged, straight into the output register.
//
// A finished result waits in the output register while the receiver stalls;
// the block meanwhile takes and works on the next sample and holds it at the
// last step until the register frees up. Reset is synchronous: it clears the
// position counter and control state and restores the register defaults.
module cosine_sum_window_apply (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [cswa_pkg::SAMPLE_BITS-1:0] sample_in,
  input  logic                                  frame_restart,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [cswa_pkg::SAMPLE_BITS-1:0] sample_out,
  output logic [cswa_pkg::POS_BITS-1:0]         position,
  output logic                                  frame_last,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [cswa_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [cswa_pkg::DATA_BITS-1:0]        pwdata,
  output logic [cswa_pkg::DATA_BITS-1:0]        prdata,
  output logic                                  pready
);

  localparam int SB = cswa_pkg::SAMPLE_BITS;
  localparam int PB = cswa_pkg::POS_BITS;
  localparam int FB = cswa_pkg::FRAME_BITS;
  localparam int RB = cswa_pkg::ROT_BITS;
  localparam int QB = cswa_pkg::PROD_BITS;

  cswa_pkg::state_t state, state_next;

  logic [cswa_pkg::KIND_BITS-1:0] window_kind;
  logic [FB-1:0]                  frame_length;
  logic [PB-1:0]                  position_counter;

  // Per-sample working registers.
  logic signed [SB-1:0]                 sample;
  logic [PB-1:0]                        pos;
  logic                                 last;
  logic [PB-1:0]                        divisor;
  logic [PB-1:0]                        rem;
  logic [cswa_pkg::PHASE_BITS-1:0]      phase;
  logic [cswa_pkg::CNT_BITS-1:0]        cnt;
  logic                                 second;
  logic [1:0]                           quad;
  logic signed [RB-1:0]                 x, y, z;
  logic signed [RB-1:0]                 c1, c2;
  logic signed [QB-1:0]                 acc;
  logic [cswa_pkg::W30_BITS-1:0]        w30;

  // Shared multiplier.
  logic signed [cswa_pkg::MUL_A_BITS-1:0] mul_a;
  logic signed [cswa_pkg::MUL_B_BITS-1:0] mul_b;
  logic signed [QB-1:0]                   mul_p;

  logic          in_accept;
  logic          out_free;
  logic          bypass;
  logic [FB-1:0] n_eff;
  logic [PB-1:0] pos_sel;
  logic [PB-1:0] pos_fix;
  logic          last_now;
  logic [PB:0]   trial;
  logic          ge;
  logic [cswa_pkg::PHASE_BITS-1:0] phase_sel;
  logic [cswa_pkg::STEP_BITS-1:0]  step;
  logic signed [RB-1:0] dx, dy, cos_val;
  logic signed [QB-1:0] w_base;
  logic signed [QB-1:0] z_full;
  logic signed [QB-1:0] res_full;
  logic signed [SB-1:0] res_sat;
  logic                 cfg_write;

  // ---------------------------------------------------------------------------
  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_kind  <= cswa_pkg::RESET_KIND;
      frame_length <= cswa_pkg::RESET_LENGTH;
    end else if (cfg_write) begin
      if (paddr[2] == cswa_pkg::REG_WINDOW_KIND) begin
        window_kind <= pwdata[cswa_pkg::KIND_BITS-1:0];
      end else begin
        frame_length <= pwdata[FB-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == cswa_pkg::REG_FRAME_LENGTH) begin
      prdata = cswa_pkg::DATA_BITS'(frame_length);
    end else begin
      prdata = cswa_pkg::DATA_BITS'(window_kind);
    end
  end

  // ---------------------------------------------------------------------------
  // Position bookkeeping for the sample being offered.
  assign n_eff    = (frame_length > FB'(cswa_pkg::MAX_FRAME)) ? FB'(cswa_pkg::MAX_FRAME)
                                                              : frame_length;
  assign bypass   = n_eff < FB'(2);
  assign pos_sel  = frame_restart ? '0 : position_counter;
  assign pos_fix  = ({1'b0, pos_sel} >= n_eff) ? '0 : pos_sel;
  assign last_now = ({1'b0, pos_fix} == (n_eff - FB'(1)));

  assign out_free  = !out_valid || !out_stall;
  assign in_accept = in_valid && !in_stall;

  // Divider step: the first step compares the position itself, the rest
  // shift in zeros from the low part of the dividend.
  assign trial = (cnt == '0) ? {1'b0, rem} : {rem, 1'b0};
  assign ge    = trial >= {1'b0, divisor};

  // CORDIC step.
  assign step = cnt[cswa_pkg::STEP_BITS-1:0];
  assign dx   = y >>> step;
  assign dy   = x >>> step;

  assign phase_sel = second ? {phase[cswa_pkg::PHASE_BITS-2:0], 1'b0} : phase;

  always_comb begin
    case (quad)
      2'd0:    cos_val = x;
      2'd1:    cos_val = -y;
      2'd2:    cos_val = -x;
      default: cos_val = y;
    endcase
  end

  always_comb begin
    case (window_kind)
      cswa_pkg::KIND_HANN:     w_base = QB'(cswa_pkg::COEF_0P50) <<< 16;
      cswa_pkg::KIND_BLACKMAN: w_base = QB'(cswa_pkg::COEF_0P42) <<< 16;
      default:                 w_base = QB'(cswa_pkg::COEF_0P54) <<< 16;
    endcase
  end

  assign mul_p  = QB'(mul_a) * QB'(mul_b);
  assign z_full = (mul_p + QB'(64'sd2097152)) >>> 22;

  // Final rounding and saturation of the sample product.
  assign res_full = (acc + QB'(64'sd536870912)) >>> 30;
  always_comb begin
    if (res_full > QB'(64'sd32767)) begin
      res_sat = SB'(16'sh7fff);
    end else if (res_full < -QB'(64'sd32768)) begin
      res_sat = SB'(16'sh8000);
    end else begin
      res_sat = res_full[SB-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      cswa_pkg::ST_IDLE: begin
        if (in_accept && !bypass) begin
          state_next = cswa_pkg::ST_DIV;
        end
      end
      cswa_pkg::ST_DIV: begin
        if (cnt == cswa_pkg::CNT_BITS'(cswa_pkg::DIV_STEPS - 1)) begin
          state_next = cswa_pkg::ST_ZMUL;
        end
      end
      cswa_pkg::ST_ZMUL: state_next = cswa_pkg::ST_ROT;
      cswa_pkg::ST_ROT: begin
        if (step == cswa_pkg::STEP_BITS'(cswa_pkg::CORDIC_STEPS - 1)) begin
          state_next = cswa_pkg::ST_COSSEL;
        end
      end
      cswa_pkg::ST_COSSEL: begin
        if (!second && window_kind == cswa_pkg::KIND_BLACKMAN) begin
          state_next = cswa_pkg::ST_ZMUL;
        end else begin
          state_next = cswa_pkg::ST_WMUL1;
        end
      end
      cswa_pkg::ST_WMUL1: begin
        if (window_kind == cswa_pkg::KIND_BLACKMAN) begin
          state_next = cswa_pkg::ST_WMUL2;
        end else begin
          state_next = cswa_pkg::ST_CLAMP;
        end
      end
      cswa_pkg::ST_WMUL2: state_next = cswa_pkg::ST_CLAMP;
      cswa_pkg::ST_CLAMP: state_next = cswa_pkg::ST_SMUL;
      cswa_pkg::ST_SMUL:  state_next = cswa_pkg::ST_FINISH;
      cswa_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = cswa_pkg::ST_IDLE;
        end
      end
      default: state_next = cswa_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs (multiplier operands and input stall).
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    in_stall = 1'b1;
    case (state)
      cswa_pkg::ST_IDLE: begin
        // A pass-through sample goes straight to the output register.
        in_stall = bypass && !out_free;
      end
      cswa_pkg::ST_ZMUL: begin
        mul_a = cswa_pkg::MUL_A_BITS'({1'b0, phase_sel[cswa_pkg::PHASE_BITS-3:0]});
        mul_b = cswa_pkg::HALF_PI_Q16;
      end
      cswa_pkg::ST_WMUL1: begin
        if (window_kind == cswa_pkg::KIND_HANN || window_kind == cswa_pkg::KIND_BLACKMAN) begin
          mul_a = cswa_pkg::MUL_A_BITS'(cswa_pkg::COEF_0P50);
        end else begin
          mul_a = cswa_pkg::MUL_A_BITS'(cswa_pkg::COEF_0P46);
        end
        mul_b = c1;
      end
      cswa_pkg::ST_WMUL2: begin
        mul_a = cswa_pkg::MUL_A_BITS'(cswa_pkg::COEF_0P08);
        mul_b = c2;
      end
      cswa_pkg::ST_SMUL: begin
        mul_a = cswa_pkg::MUL_A_BITS'({1'b0, w30});
        mul_b = cswa_pkg::MUL_B_BITS'(sample);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= cswa_pkg::ST_IDLE;
      position_counter <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (in_accept) begin
        if (bypass) begin
          position_counter <= '0;
        end else begin
          position_counter <= last_now ? '0 : pos_fix + PB'(1);
        end
      end
      if ((in_accept && bypass) || (state == cswa_pkg::ST_FINISH && out_free)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      cswa_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (bypass) begin
            sample_out <= sample_in;
            position   <= '0;
            frame_last <= 1'b1;
          end else begin
            sample  <= sample_in;
            pos     <= pos_fix;
            last    <= last_now;
            divisor <= PB'(n_eff - FB'(1));
            rem     <= pos_fix;
            cnt     <= '0;
            second  <= 1'b0;
          end
        end
      end
      cswa_pkg::ST_DIV: begin
        rem   <= ge ? PB'(trial - {1'b0, divisor}) : trial[PB-1:0];
        phase <= {phase[cswa_pkg::PHASE_BITS-2:0], ge};
        cnt   <= cnt + cswa_pkg::CNT_BITS'(1);
      end
      cswa_pkg::ST_ZMUL: begin
        quad <= phase_sel[cswa_pkg::PHASE_BITS-1:cswa_pkg::PHASE_BITS-2];
        x    <= cswa_pkg::CORDIC_GAIN;
        y    <= '0;
        z    <= z_full[RB-1:0];
        cnt  <= '0;
      end
      cswa_pkg::ST_ROT: begin
        if (!z[RB-1]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - cswa_pkg::atan_q16(step);
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + cswa_pkg::atan_q16(step);
        end
        cnt <= cnt + cswa_pkg::CNT_BITS'(1);
      end
      cswa_pkg::ST_COSSEL: begin
        if (second) begin
          c2 <= cos_val;
        end else begin
          c1     <= cos_val;
          second <= 1'b1;
        end
      end
      cswa_pkg::ST_WMUL1: acc <= w_base - mul_p;
      cswa_pkg::ST_WMUL2: acc <= acc + mul_p;
      cswa_pkg::ST_CLAMP: begin
        // Coefficient clamped to [0, 1.0] and rounded from Q2.32 to Q2.30.
        if (acc < 0) begin
          w30 <= '0;
        end else if (acc > (QB'(64'sd1) <<< 32)) begin
          w30 <= cswa_pkg::W30_BITS'(1) << 30;
        end else begin
          w30 <= cswa_pkg::W30_BITS'((acc + QB'(2)) >>> 2);
        end
      end
      cswa_pkg::ST_SMUL: acc <= mul_p;
      cswa_pkg::ST_FINISH: begin
        if (out_free) begin
          sample_out <= res_sat;
          position   <= pos;
          frame_last <= last;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  // The divider leaves a proper remainder before the CORDIC angle is formed.
  assert property (@(posedge clk) disable iff (rst)
    state == cswa_pkg::ST_ZMUL |-> rem < divisor)
    else $error("divider remainder not below divisor");

  // The coefficient never exceeds one in Q2.30.
  assert property (@(posedge clk) disable iff (rst)
    state == cswa_pkg::ST_SMUL |-> w30 <= (cswa_pkg::W30_BITS'(1) << 30))
    else $error("window coefficient above one");

  // The second cosine term is only used for the Blackman window.
  assert property (@(posedge clk) disable iff (rst)
    state == cswa_pkg::ST_WMUL2 |-> window_kind == cswa_pkg::KIND_BLACKMAN && second)
    else $error("second cosine term used outside Blackman");

  // A finished sample lands in the output register and frees the sequencer.
  assert property (@(posedge clk) disable iff (rst)
    state == cswa_pkg::ST_FINISH && out_free |=> out_valid && state == cswa_pkg::ST_IDLE)
    else $error("finished sample not delivered");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for cosine_sum_window_apply: a directed table, then random frames.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_200_000;
  localparam int RANDOM_ITEMS = 1030;
  localparam int END_TAIL     = 200;

  typedef struct packed {
    logic signed [cswa_pkg::SAMPLE_BITS-1:0] sample;
    logic [cswa_pkg::POS_BITS-1:0]           pos;
    logic                                    last;
  } win_result_t;

  typedef enum {ROW_KIND, ROW_LENGTH, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t kind;
    int        value;
    bit        restart;
    bit        checked;
    int        exp_sample;
    int        exp_pos;
    bit        exp_last;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [cswa_pkg::SAMPLE_BITS-1:0] sample_in;
  logic frame_restart;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [cswa_pkg::SAMPLE_BITS-1:0] sample_out;
  logic [cswa_pkg::POS_BITS-1:0] position;
  logic frame_last;
  logic psel;
  logic penable;
  logic pwrite;
  logic [cswa_pkg::ADDR_BITS-1:0] paddr;
  logic [cswa_pkg::DATA_BITS-1:0] pwdata;
  logic [cswa_pkg::DATA_BITS-1:0] prdata;
  logic pready;

  // Predictor state, kept in step with the block's registers and counter.
  logic [1:0]                    cfg_kind;
  logic [12:0]                   cfg_length;
  logic [cswa_pkg::POS_BITS-1:0] next_pos;

  win_result_t win_expected[$];
  win_result_t seen_want;
  stim_row_t   stim_table[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          quiet = 1'b0;

  cosine_sum_window_apply dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_in(sample_in), .frame_restart(frame_restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .sample_out(sample_out), .position(position), .frame_last(frame_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  // Cosine of a Q0.24 fraction of a turn, in Q2.16, by a 16-step rotation.
  function automatic longint cordic_cos(input logic [23:0] phase);
    longint x, y, z, dx, dy, atan_k;
    x = 39797;
    y = 0;
    z = (longint'(phase[21:0]) * 102944 + (longint'(1) << 21)) >>> 22;
    for (int k = 0; k < 16; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      atan_k = longint'($atan(1.0 / (1 << k)) * 65536.0);
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_k;
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_k;
      end
    end
    case (phase[23:22])
      2'd0:    return x;
      2'd1:    return -y;
      2'd2:    return -x;
      default: return y;
    endcase
  endfunction

  function automatic win_result_t predict_window(
      input logic signed [cswa_pkg::SAMPLE_BITS-1:0] s, input logic restart);
    longint n, pos, c, c2, w32, w30, prod, res;
    logic [23:0] phase;
    logic last;
    win_result_t r;
    n = cfg_length;
    if (n > 4096) n = 4096;
    // Short frames pass the sample through untouched.
    if (n < 2) begin
      next_pos = '0;
      r.sample = s;
      r.pos = '0;
      r.last = 1'b1;
      return r;
    end
    pos = restart ? 0 : longint'(next_pos);
    if (pos >= n) pos = 0;
    last = (pos == n - 1);
    next_pos = last ? '0 : cswa_pkg::POS_BITS'(pos + 1);
    phase = 24'((pos << 24) / (n - 1));
    c = cordic_cos(phase);
    case (cfg_kind)
      cswa_pkg::KIND_HANN: w32 = longint'(32768) * 65536 - 32768 * c;
      cswa_pkg::KIND_BLACKMAN: begin
        c2 = cordic_cos({phase[22:0], 1'b0});
        w32 = longint'(27525) * 65536 - 32768 * c + 5243 * c2;
      end
      default: w32 = longint'(35389) * 65536 - 30147 * c;
    endcase
    if (w32 < 0) w32 = 0;
    if (w32 > (longint'(1) << 32)) w32 = longint'(1) << 32;
    w30 = (w32 + 2) >>> 2;
    prod = longint'(s) * w30;
    res = (prod + (longint'(1) << 29)) >>> 30;
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    r.sample = res[cswa_pkg::SAMPLE_BITS-1:0];
    r.pos = cswa_pkg::POS_BITS'(pos);
    r.last = last;
    return r;
  endfunction

  function automatic stim_row_t make_row(input row_kind_t kind, input int value,
                                         input bit restart = 1'b0, input bit checked = 1'b0,
                                         input int exp_sample = 0, input int exp_pos = 0,
                                         input bit exp_last = 1'b0);
    stim_row_t row;
    row.kind = kind;
    row.value = value;
    row.restart = restart;
    row.checked = checked;
    row.exp_sample = exp_sample;
    row.exp_pos = exp_pos;
    row.exp_last = exp_last;
    return row;
  endfunction

  function automatic int idle_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 90);
  endfunction

  function automatic logic signed [cswa_pkg::SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return cswa_pkg::SAMPLE_BITS'($urandom_range(0, 3) - 1);
      default: return cswa_pkg::SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic int pick_length();
    case ($urandom_range(0, 15))
      0:       return $urandom_range(0, 1);
      1:       return $urandom_range(4096, 8191);
      2:       return $urandom_range(100, 4096);
      default: return $urandom_range(2, 48);
    endcase
  endfunction

  // Offers one sample and waits for the transaction; valid stays high afterwards.
  task automatic drive_sample(input logic signed [cswa_pkg::SAMPLE_BITS-1:0] s,
                              input logic restart,
                              input bit use_typed, input win_result_t typed);
    int gap;
    win_result_t predicted;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= s;
    frame_restart <= restart;
    do @(posedge clk); while (in_stall);
    predicted = predict_window(s, restart);
    win_expected.push_back(use_typed ? typed : predicted);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (win_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes a register, then reads it back.
  task automatic write_register(input logic reg_index, input int value);
    logic [cswa_pkg::DATA_BITS-1:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_index == cswa_pkg::REG_WINDOW_KIND) begin
      cfg_kind = value[1:0];
      want = cswa_pkg::DATA_BITS'(value[1:0]);
    end else begin
      cfg_length = value[12:0];
      want = cswa_pkg::DATA_BITS'(value[12:0]);
    end
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want)
      report_mismatch($sformatf("register %0d read back: expected %0d, got %0d",
                                reg_index, want, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // The receiver stalls in runs: mostly short, now and then long.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100)
                                                : $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (win_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result: sample %0d pos %0d last %0d",
                                  sample_out, position, frame_last));
      end else begin
        seen_want = win_expected.pop_front();
        if (sample_out !== seen_want.sample || position !== seen_want.pos ||
            frame_last !== seen_want.last)
          report_mismatch($sformatf(
            "result mismatch: expected sample %0d pos %0d last %0d, got sample %0d pos %0d last %0d",
            seen_want.sample, seen_want.pos, seen_want.last,
            sample_out, position, frame_last));
      end
    end
  end

  initial begin
    win_result_t typed;
    int sent;
    int count;
    int kind_value;
    int length_value;

    rst = 1'b1;
    in_valid = 1'b0;
    sample_in = '0;
    frame_restart = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_kind = cswa_pkg::KIND_HAMMING;
    cfg_length = 13'd1024;
    next_pos = '0;

    // Reset settings first: Hamming over 1024 samples.
    stim_table.push_back(make_row(ROW_SAMPLE, 0, 1'b1, 1'b1, 0, 0, 1'b0));
    stim_table.push_back(make_row(ROW_SAMPLE, 32767));
    stim_table.push_back(make_row(ROW_SAMPLE, -32768));
    stim_table.push_back(make_row(ROW_SAMPLE, -1, 1'b1));
    stim_table.push_back(make_row(ROW_KIND, cswa_pkg::KIND_HANN));
    stim_table.push_back(make_row(ROW_SAMPLE, 32767));
    // The counter sits at 2 when the frame shrinks to 2, so the next sample restarts at 0.
    stim_table.push_back(make_row(ROW_LENGTH, 2));
    stim_table.push_back(make_row(ROW_SAMPLE, -32768));
    stim_table.push_back(make_row(ROW_SAMPLE, 32767));
    stim_table.push_back(make_row(ROW_KIND, cswa_pkg::KIND_BLACKMAN));
    stim_table.push_back(make_row(ROW_LENGTH, 3));
    stim_table.push_back(make_row(ROW_SAMPLE, 32767));
    stim_table.push_back(make_row(ROW_SAMPLE, -32768));
    stim_table.push_back(make_row(ROW_SAMPLE, 12345));
    // The unused kind code behaves as Hamming.
    stim_table.push_back(make_row(ROW_KIND, 3));
    stim_table.push_back(make_row(ROW_SAMPLE, -32768));
    stim_table.push_back(make_row(ROW_SAMPLE, 32767));
    stim_table.push_back(make_row(ROW_LENGTH, 0));
    stim_table.push_back(make_row(ROW_SAMPLE, -32768, 1'b0, 1'b1, -32768, 0, 1'b1));
    stim_table.push_back(make_row(ROW_SAMPLE, 32767, 1'b1, 1'b1, 32767, 0, 1'b1));
    stim_table.push_back(make_row(ROW_LENGTH, 1));
    stim_table.push_back(make_row(ROW_SAMPLE, 21845, 1'b0, 1'b1, 21845, 0, 1'b1));
    stim_table.push_back(make_row(ROW_SAMPLE, -21846, 1'b1, 1'b1, -21846, 0, 1'b1));
    // Oversized frame length is clipped to the largest frame.
    stim_table.push_back(make_row(ROW_LENGTH, 8191));
    stim_table.push_back(make_row(ROW_KIND, cswa_pkg::KIND_HAMMING));
    stim_table.push_back(make_row(ROW_SAMPLE, 32767));
    stim_table.push_back(make_row(ROW_SAMPLE, -32768));
    stim_table.push_back(make_row(ROW_SAMPLE, 100));
    stim_table.push_back(make_row(ROW_LENGTH, 4096));
    stim_table.push_back(make_row(ROW_LENGTH, 3));
    stim_table.push_back(make_row(ROW_SAMPLE, 32767));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_table[i]) begin
      case (stim_table[i].kind)
        ROW_KIND: begin
          wait_idle();
          write_register(cswa_pkg::REG_WINDOW_KIND, stim_table[i].value);
        end
        ROW_LENGTH: begin
          wait_idle();
          write_register(cswa_pkg::REG_FRAME_LENGTH, stim_table[i].value);
        end
        default: begin
          typed.sample = stim_table[i].exp_sample[cswa_pkg::SAMPLE_BITS-1:0];
          typed.pos = stim_table[i].exp_pos[cswa_pkg::POS_BITS-1:0];
          typed.last = stim_table[i].exp_last;
          drive_sample(stim_table[i].value[cswa_pkg::SAMPLE_BITS-1:0],
                       stim_table[i].restart, stim_table[i].checked, typed);
        end
      endcase
    end

    // Random frames under a fresh setting for each batch.
    sent = 0;
    typed = '0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      kind_value = $urandom_range(0, 3);
      length_value = pick_length();
      if ($urandom_range(0, 1) == 0) begin
        write_register(cswa_pkg::REG_WINDOW_KIND, kind_value);
        write_register(cswa_pkg::REG_FRAME_LENGTH, length_value);
      end else begin
        write_register(cswa_pkg::REG_FRAME_LENGTH, length_value);
        write_register(cswa_pkg::REG_WINDOW_KIND, kind_value);
      end
      quiet = ($urandom_range(0, 4) == 0);
      count = $urandom_range(30, 90);
      repeat (count) begin
        drive_sample(random_sample(), ($urandom_range(0, 19) == 0), 1'b0, typed);
        sent++;
        if ($urandom_range(0, 149) == 0) wait_idle();
      end
    end

    quiet = 1'b0;
    wait_idle();
    repeat (END_TAIL) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
